@@ rtl/cht_pkg.sv @@
// ----------------------------------------------------------------------------
// cht_pkg: shared types and codes for the chained hash table
// Item structs, result status codes and the control/status bundles
// that link the controller and the datapath.
// ----------------------------------------------------------------------------
package cht_pkg;

	localparam int KEY_W  = 31;
	localparam int VAL_W  = 32;
	localparam int STAT_W = 3;
	localparam int CFG_W  = 5;

	// operation codes
	localparam logic FUNC_PUT = 1'b0;
	localparam logic FUNC_GET = 1'b1;

	// result status codes
	localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
	localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd1;
	localparam logic [STAT_W-1:0] ST_FOUND     = 3'd2;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
	localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;

	localparam logic [CFG_W-1:0] BUCKET_COUNT_RST = 5'd16;

	typedef struct packed {
		logic             func;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} req_item_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [VAL_W-1:0]  value_out;
	} rsp_item_t;

	// controller -> datapath
	typedef struct packed {
		logic clr_step;   // clear one fill counter
		logic accept;     // latch request, start the modulo
		logic div_step;   // one remainder bit
		logic way_inc;    // advance the scan
		logic hit;        // record a key match
		logic decide;     // form result, commit a put
		logic load_out;   // move result to the output register
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_last;
		logic div_last;
		logic way_end;
		logic key_match;
		logic out_free;
	} dp_sts_t;

endpackage

@@ rtl/chained_hash_table_put_get_top.sv @@
// ----------------------------------------------------------------------------
// chained_hash_table_put_get_top: bounded chained hash table, put and get
// Keyed store of NUM_BUCKETS buckets with WAYS entries each; one result
// item per request item.
// ----------------------------------------------------------------------------
// Usage: one request item at a time; req_stall is high from acceptance until
// the result has been handed to the output register, which holds it while
// rsp_stall is high and lets the next request in meanwhile. An item is taken
// in idle, then goes through the bit-serial key modulo, the fill count read,
// and the scan of the filled ways of its bucket through the registered entry
// memory port, stopping at the first match, with an end-of-bucket check on a
// miss; then come commit and hand-off, which a held output delays.
// After reset the block sweeps the fill counters with req_stall high;
// configuration writes are taken at any time (cfg_ready is tied high) but
// must only be issued while no item is in flight. A bucket_count of zero
// acts as one, above NUM_BUCKETS it saturates; on a get with no match
// value_out is zero.
module chained_hash_table_put_get_top #(
	parameter int NUM_BUCKETS = 16,
	parameter int WAYS        = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// request channel
	input  logic                      req_valid,
	output logic                      req_stall,
	input  cht_pkg::req_item_t        req,
	// response channel
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output cht_pkg::rsp_item_t        rsp,
	// bucket_count write
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [cht_pkg::CFG_W-1:0] cfg_data
);

	cht_pkg::dp_cmd_t cmd;
	cht_pkg::dp_sts_t sts;

	// register write never waits
	assign cfg_ready = 1'b1;

	cht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	cht_dp #(
		.NUM_BUCKETS(NUM_BUCKETS),
		.WAYS       (WAYS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.req      (req),
		.rsp      (rsp),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule

@@ rtl/cht_dp.sv @@
// ----------------------------------------------------------------------------
// cht_dp: hash table datapath
// Bucket count register, bit-serial modulo, fill counter memory, entry
// memory, way compare and the output register.
// ----------------------------------------------------------------------------
module cht_dp #(
	parameter int NUM_BUCKETS = 16,
	parameter int WAYS        = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [cht_pkg::CFG_W-1:0] cfg_data,
	input  cht_pkg::req_item_t        req,
	output cht_pkg::rsp_item_t        rsp,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	input  cht_pkg::dp_cmd_t          cmd,
	output cht_pkg::dp_sts_t          sts
);

	localparam int BW      = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int ENTRIES = NUM_BUCKETS * WAYS;
	localparam int EW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int WCW     = $clog2(WAYS + 1);
	localparam int DCW     = $clog2(cht_pkg::KEY_W);
	localparam int ENT_W   = cht_pkg::KEY_W + cht_pkg::VAL_W;

	// configuration
	logic [cht_pkg::CFG_W-1:0] bcount_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcount_q <= cht_pkg::BUCKET_COUNT_RST;
		end else if (cfg_we) begin
			bcount_q <= cfg_data;
		end
	end

	// effective modulus: zero reads as one, saturate at the bucket count
	logic [cht_pkg::CFG_W-1:0] mod_d;

	always_comb begin
		mod_d = bcount_q;
		if (bcount_q == '0) begin
			mod_d = cht_pkg::CFG_W'(1);
		end else if (int'(bcount_q) > NUM_BUCKETS) begin
			mod_d = cht_pkg::CFG_W'(NUM_BUCKETS);
		end
	end

	// request registers
	logic                       func_q;
	logic [cht_pkg::KEY_W-1:0]  key_q;
	logic [cht_pkg::VAL_W-1:0]  val_q;
	logic [cht_pkg::KEY_W-1:0]  key_sh_q;
	logic [cht_pkg::CFG_W-1:0]  mod_q;
	logic [cht_pkg::CFG_W-1:0]  rem_q;
	logic [DCW-1:0]             div_cnt_q;
	logic [WCW-1:0]             way_q;
	logic                       hit_q;
	logic [cht_pkg::VAL_W-1:0]  hit_val_q;

	// restoring remainder step
	logic [cht_pkg::CFG_W:0]    trial;
	logic [cht_pkg::CFG_W-1:0]  rem_d;

	always_comb begin
		trial = {rem_q, key_sh_q[cht_pkg::KEY_W-1]};
		if (trial >= {1'b0, mod_q}) begin
			rem_d = cht_pkg::CFG_W'(trial - {1'b0, mod_q});
		end else begin
			rem_d = trial[cht_pkg::CFG_W-1:0];
		end
	end

	logic [BW-1:0] bucket;
	assign bucket = BW'(rem_q);

	// memories
	logic [WCW-1:0]   fill_mem [NUM_BUCKETS];
	logic [ENT_W-1:0] ent_mem  [ENTRIES];
	logic [WCW-1:0]   fill_rd_q;
	logic [ENT_W-1:0] ent_rd_q;
	logic [BW-1:0]    clr_q;
	logic [EW-1:0]    ent_addr;

	assign ent_addr = EW'(int'(bucket) * WAYS + int'(way_q));

	logic ins_ok;
	assign ins_ok = (func_q == cht_pkg::FUNC_PUT) && !hit_q && (fill_rd_q < WCW'(WAYS));

	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			fill_mem[clr_q] <= '0;
		end else if (cmd.decide && ins_ok) begin
			fill_mem[bucket] <= fill_rd_q + WCW'(1);
		end
		fill_rd_q <= fill_mem[bucket];
	end

	always_ff @(posedge clk) begin
		if (cmd.decide && ins_ok) begin
			ent_mem[ent_addr] <= {key_q, val_q};
		end
		ent_rd_q <= ent_mem[ent_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= clr_q + BW'(1);
		end
	end

	// request and scan state
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q    <= req.func;
			key_q     <= req.key;
			val_q     <= req.value;
			key_sh_q  <= req.key;
			mod_q     <= mod_d;
			rem_q     <= '0;
			div_cnt_q <= DCW'(cht_pkg::KEY_W - 1);
			way_q     <= '0;
			hit_q     <= 1'b0;
		end else begin
			if (cmd.div_step) begin
				rem_q     <= rem_d;
				key_sh_q  <= {key_sh_q[cht_pkg::KEY_W-2:0], 1'b0};
				div_cnt_q <= div_cnt_q - DCW'(1);
			end
			if (cmd.way_inc) begin
				way_q <= way_q + WCW'(1);
			end
			if (cmd.hit) begin
				hit_q     <= 1'b1;
				hit_val_q <= ent_rd_q[cht_pkg::VAL_W-1:0];
			end
		end
	end

	// result
	cht_pkg::rsp_item_t res_q;

	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			if (func_q == cht_pkg::FUNC_GET) begin
				if (hit_q) begin
					res_q.status    <= cht_pkg::ST_FOUND;
					res_q.value_out <= hit_val_q;
				end else begin
					res_q.status    <= cht_pkg::ST_NOT_FOUND;
					res_q.value_out <= '0;
				end
			end else begin
				res_q.value_out <= '0;
				if (hit_q) begin
					res_q.status <= cht_pkg::ST_DUPLICATE;
				end else if (!ins_ok) begin
					res_q.status <= cht_pkg::ST_FULL;
				end else begin
					res_q.status <= cht_pkg::ST_INSERTED;
				end
			end
		end
	end

	// output register
	logic rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			rsp <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;

	assign sts.clr_last  = (clr_q == BW'(NUM_BUCKETS - 1));
	assign sts.div_last  = (div_cnt_q == '0);
	assign sts.way_end   = (way_q == fill_rd_q);
	assign sts.key_match = (ent_rd_q[ENT_W-1:cht_pkg::VAL_W] == key_q);
	assign sts.out_free  = !rsp_valid_q || !rsp_stall;

endmodule

@@ rtl/cht_ctrl.sv @@
// ----------------------------------------------------------------------------
// cht_ctrl: hash table sequencer
// Clears the fill counters after reset, then walks each request through
// modulo, fill read, way scan, commit and result hand-off.
// ----------------------------------------------------------------------------
module cht_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  cht_pkg::dp_sts_t sts,
	output cht_pkg::dp_cmd_t cmd
);

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_DIV    = 3'd2;
	localparam logic [2:0] S_FILL   = 3'd3;
	localparam logic [2:0] S_SCAN   = 3'd4;
	localparam logic [2:0] S_CMP    = 3'd5;
	localparam logic [2:0] S_DECIDE = 3'd6;
	localparam logic [2:0] S_FIN    = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_FILL;
				end
			end
			// fill count read for the bucket is issued here
			S_FILL: begin
				state_d = S_SCAN;
			end
			S_SCAN: begin
				if (sts.way_end) begin
					state_d = S_DECIDE;
				end else begin
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				if (sts.key_match) begin
					cmd.hit = 1'b1;
					state_d = S_DECIDE;
				end else begin
					cmd.way_inc = 1'b1;
					state_d     = S_SCAN;
				end
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = S_FIN;
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_stall = (state_q != S_IDLE);

endmodule

@@ rtl/cht_check.sv @@
// ----------------------------------------------------------------------------
// cht_check: port-level checks for the hash table
// Watches the top level's ports and flags result or handshake slips.
// ----------------------------------------------------------------------------
module cht_check (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_stall,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input cht_pkg::rsp_item_t rsp
);

	// a held result stays put
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// only one request in flight
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken back to back");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.status == cht_pkg::ST_INSERTED
			|| rsp.status == cht_pkg::ST_DUPLICATE
			|| rsp.status == cht_pkg::ST_FOUND
			|| rsp.status == cht_pkg::ST_NOT_FOUND
			|| rsp.status == cht_pkg::ST_FULL)
		else $error("bad status code");

	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != cht_pkg::ST_FOUND |-> rsp.value_out == '0)
		else $error("value_out not zero without a hit");

endmodule

bind chained_hash_table_put_get_top cht_check u_cht_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_stall(req_stall),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp      (rsp)
);

@@ tb/chained_hash_table_put_get_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_table_put_get_top_tb: self-checking bench for the hash table
// Drives put/get request items and bucket_count writes. A shadow copy of the
// table predicts each response item, and responses are checked in order.
// Random bursts and gaps are used on the request side and random stall runs
// on the response side, including one long output hold and full drains.
// ----------------------------------------------------------------------------
module chained_hash_table_put_get_top_tb;

	localparam int NUM_BUCKETS     = 16;
	localparam int WAYS            = 4;
	localparam int ITEMS_PER_PHASE = 110;
	localparam int IDLE_LIMIT      = 3000;  // cycles with no handshake at all
	localparam int END_WAIT        = 50;    // longer than the slowest item takes
	localparam int SETTLE          = 4;
	localparam int LONG_HOLD       = 400;

	logic                        clk;
	logic                        arst_n    = 1'b0;
	logic                        req_valid = 1'b0;
	logic                        req_stall;
	cht_pkg::req_item_t          req       = '0;
	logic                        rsp_valid;
	logic                        rsp_stall = 1'b0;
	cht_pkg::rsp_item_t          rsp;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic [cht_pkg::CFG_W-1:0]   cfg_data  = '0;

	// shadow of the table contents and the bucket_count register
	logic [cht_pkg::KEY_W-1:0] shadow_key [NUM_BUCKETS*WAYS];
	logic [cht_pkg::VAL_W-1:0] shadow_val [NUM_BUCKETS*WAYS];
	int unsigned               shadow_fill [NUM_BUCKETS];
	logic [cht_pkg::CFG_W-1:0] shadow_bucket_count;

	cht_pkg::rsp_item_t        rsp_pending_q[$];  // responses still owed by the block
	logic [cht_pkg::KEY_W-1:0] key_pool[$];
	logic [cht_pkg::KEY_W-1:0] recent_put_keys[$];

	int errors        = 0;
	int burst_left    = 1;
	int gap_max       = 0;   // 0: request valid never drops between items
	int stall_pct     = 0;   // share of response stall runs
	int hold_request  = 0;   // long response hold, picked up by the stall process

	chained_hash_table_put_get_top #(
		.NUM_BUCKETS(NUM_BUCKETS),
		.WAYS       (WAYS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ---------------------------------------------------------------------
	// Table prediction: bucket = key mod effective count, first-match scan.
	// A zero count acts as one; above NUM_BUCKETS it saturates.
	// ---------------------------------------------------------------------
	function automatic cht_pkg::rsp_item_t table_apply(input cht_pkg::req_item_t r);
		cht_pkg::rsp_item_t res;
		int unsigned        modulo;
		int unsigned        bucket;
		int unsigned        base;
		int                 hit_way;
		modulo = (shadow_bucket_count == 0) ? 1 :
			((shadow_bucket_count > NUM_BUCKETS) ? NUM_BUCKETS : shadow_bucket_count);
		bucket  = r.key % modulo;
		base    = bucket * WAYS;
		hit_way = -1;
		for (int w = 0; w < WAYS; w++) begin
			if (hit_way < 0 && w < shadow_fill[bucket] && shadow_key[base + w] == r.key)
				hit_way = w;
		end
		res.value_out = '0;
		if (r.func == cht_pkg::FUNC_PUT) begin
			if (hit_way >= 0) begin
				res.status = cht_pkg::ST_DUPLICATE;
			end else if (shadow_fill[bucket] >= WAYS) begin
				res.status = cht_pkg::ST_FULL;
			end else begin
				shadow_key[base + shadow_fill[bucket]] = r.key;
				shadow_val[base + shadow_fill[bucket]] = r.value;
				shadow_fill[bucket]++;
				res.status = cht_pkg::ST_INSERTED;
			end
		end else begin
			if (hit_way >= 0) begin
				res.status    = cht_pkg::ST_FOUND;
				res.value_out = shadow_val[base + hit_way];
			end else begin
				res.status = cht_pkg::ST_NOT_FOUND;
			end
		end
		return res;
	endfunction

	// ---------------------------------------------------------------------
	// Request side: one item per call, bursts of random length, random gaps.
	// valid is only dropped at the end of a burst or for a drain, so it is never
	// lowered and raised in the same step.
	// ---------------------------------------------------------------------
	task automatic send_item(input cht_pkg::req_item_t item);
		req       <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		rsp_pending_q = {rsp_pending_q, table_apply(item)};
		if (item.func == cht_pkg::FUNC_PUT) begin
			recent_put_keys = {recent_put_keys, item.key};
			if (recent_put_keys.size() > 32)
				void'(recent_put_keys.pop_front());
		end
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 8);
			if (gap_max != 0) begin
				req_valid <= 1'b0;
				repeat ($urandom_range(1, gap_max)) @(posedge clk);
			end
		end
	endtask

	task automatic issue(input logic func, input logic [cht_pkg::KEY_W-1:0] key,
			input logic [cht_pkg::VAL_W-1:0] value);
		cht_pkg::req_item_t item;
		item.func  = func;
		item.key   = key;
		item.value = value;
		send_item(item);
	endtask

	// Stop offering and wait until every owed response item is back.
	task automatic wait_drained();
		req_valid <= 1'b0;
		while (rsp_pending_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Register writes only with the block idle.
	task automatic set_bucket_count(input logic [cht_pkg::CFG_W-1:0] count);
		wait_drained();
		cfg_data  <= count;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		shadow_bucket_count = count;
	endtask

	// Keys: mostly a small pool and recently put keys so that hits,
	// duplicates and full buckets are common; the rest span all 31 bits.
	function automatic cht_pkg::req_item_t random_request();
		cht_pkg::req_item_t r;
		int                 pick;
		r.func  = 1'($urandom_range(0, 1));
		r.value = $urandom();
		pick    = $urandom_range(0, 99);
		if (pick < 45)
			r.key = key_pool[$urandom_range(0, key_pool.size() - 1)];
		else if (pick < 75 && recent_put_keys.size() != 0)
			r.key = recent_put_keys[$urandom_range(0, recent_put_keys.size() - 1)];
		else
			r.key = cht_pkg::KEY_W'($urandom());
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// Response side: stall runs of random length; a hold request forces a
	// long stretch of stall counted here.
	// ---------------------------------------------------------------------
	initial begin : rsp_stall_gen
		int run_left;
		int hold_left;
		bit stalling;
		run_left  = 0;
		hold_left = 0;
		stalling  = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				rsp_stall <= 1'b1;
				hold_left--;
			end else begin
				if (run_left <= 0) begin
					stalling = ($urandom_range(0, 99) < stall_pct);
					run_left = stalling ? $urandom_range(1, 12) : $urandom_range(1, 30);
				end
				rsp_stall <= stalling;
				run_left--;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Response check, in order against the oldest prediction.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin : rsp_check
		cht_pkg::rsp_item_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (rsp_pending_q.size() == 0) begin
				$error("response item with none pending: status=%0d value_out=%0h",
					rsp.status, rsp.value_out);
				errors++;
			end else begin
				want = rsp_pending_q.pop_front();
				if (rsp.status !== want.status) begin
					$error("status mismatch: expected %0d, got %0d", want.status, rsp.status);
					errors++;
				end
				if (rsp.value_out !== want.value_out) begin
					$error("value_out mismatch: expected %0h, got %0h",
						want.value_out, rsp.value_out);
					errors++;
				end
			end
		end
	end

	// Watchdog: ends the run after too long without any handshake.
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
					(cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// Reset count of 16: miss on empty, key/value extremes, duplicate,
	// filling one bucket, full on a new key, duplicate on a full bucket.
	task automatic test_basic_ops();
		gap_max   = 4;
		stall_pct = 30;
		issue(cht_pkg::FUNC_GET, 31'd0, 32'hFFFF_FFFF);
		issue(cht_pkg::FUNC_PUT, 31'd0, 32'h0000_0000);
		issue(cht_pkg::FUNC_PUT, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
		issue(cht_pkg::FUNC_GET, 31'h7FFF_FFFF, 32'h0);
		issue(cht_pkg::FUNC_GET, 31'd0, $urandom());
		issue(cht_pkg::FUNC_PUT, 31'd0, 32'h1234_5678);
		// bucket 3 takes all four ways
		issue(cht_pkg::FUNC_PUT, 31'd3,  $urandom());
		issue(cht_pkg::FUNC_PUT, 31'd19, $urandom());
		issue(cht_pkg::FUNC_PUT, 31'd35, $urandom());
		issue(cht_pkg::FUNC_PUT, 31'd51, $urandom());
		issue(cht_pkg::FUNC_PUT, 31'd67, $urandom());
		issue(cht_pkg::FUNC_PUT, 31'd19, $urandom());
		issue(cht_pkg::FUNC_GET, 31'd51, $urandom());
		issue(cht_pkg::FUNC_GET, 31'd67, $urandom());
		wait_drained();
	endtask

	// Count of zero acts as one, above 16 saturates; changing the count
	// hides entries placed under the old modulus.
	task automatic test_bucket_count_extremes();
		set_bucket_count(5'd0);
		issue(cht_pkg::FUNC_GET, 31'd3, $urandom());
		issue(cht_pkg::FUNC_PUT, 31'd5, 32'hA5A5_5A5A);
		issue(cht_pkg::FUNC_GET, 31'd0, $urandom());
		set_bucket_count(5'd31);
		issue(cht_pkg::FUNC_GET, 31'd5, $urandom());
		issue(cht_pkg::FUNC_GET, 31'h7FFF_FFFF, $urandom());
		set_bucket_count(5'd1);
		issue(cht_pkg::FUNC_PUT, 31'h5555_5555, 32'hAAAA_AAAA);
		issue(cht_pkg::FUNC_GET, 31'h5555_5555, $urandom());
		set_bucket_count(5'd16);
		issue(cht_pkg::FUNC_GET, 31'd19, $urandom());
		wait_drained();
	endtask

	// Random traffic in phases, each under its own count and pacing.
	task automatic test_random_traffic();
		logic [cht_pkg::CFG_W-1:0] phase_count [8];
		int                        gap_choice  [3];
		int                        stall_choice[3];
		phase_count  = '{5'd7, 5'd16, 5'd31, 5'd1, 5'd0, 5'd13, 5'd3, 5'd16};
		gap_choice   = '{0, 4, 50};
		stall_choice = '{0, 30, 70};
		phase_count[7] = cht_pkg::CFG_W'($urandom_range(0, 31));
		foreach (phase_count[p]) begin
			set_bucket_count(phase_count[p]);
			gap_max   = gap_choice[$urandom_range(0, 2)];
			stall_pct = stall_choice[$urandom_range(0, 2)];
			repeat (ITEMS_PER_PHASE) send_item(random_request());
		end
		wait_drained();
	endtask

	// Long output hold while requests keep coming, so the block backs up
	// and stalls its input; then a full drain before more traffic.
	task automatic test_output_backpressure();
		set_bucket_count(5'd16);
		gap_max      = 0;
		stall_pct    = 0;
		hold_request = LONG_HOLD;
		repeat (12) send_item(random_request());
		wait_drained();
		stall_pct = 50;
		repeat (20) send_item(random_request());
		wait_drained();
	endtask

	initial begin : main
		key_pool = {};
		for (int k = 0; k <= 20; k++) key_pool = {key_pool, cht_pkg::KEY_W'(k)};
		repeat (8) key_pool = {key_pool, cht_pkg::KEY_W'($urandom())};
		key_pool = {key_pool, 31'h7FFF_FFFF};
		for (int b = 0; b < NUM_BUCKETS; b++) shadow_fill[b] = 0;
		shadow_bucket_count = cht_pkg::BUCKET_COUNT_RST;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_basic_ops();
		test_bucket_count_extremes();
		test_output_backpressure();
		test_random_traffic();

		wait_drained();
		repeat (END_WAIT) @(posedge clk);
		if (errors == 0 && rsp_pending_q.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ chained_hash_table_put_get_top.f @@
rtl/cht_pkg.sv
rtl/cht_dp.sv
rtl/cht_ctrl.sv
rtl/chained_hash_table_put_get_top.sv
rtl/cht_check.sv
tb/chained_hash_table_put_get_top_tb.sv
